@@ design/range_minimum_segment_tree_top_assert.svh @@
// Assertion macros of the range minimum segment tree RTL, used by rmst_back.
// Used by files that take this header with `include; needs no package.
`ifndef RANGE_MINIMUM_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_TOP_ASSERT_SVH

// same-cycle implication
`define RMST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rmst_pkg.sv @@
// Shared types and constants of the range minimum segment tree.
// No dependencies; imported by the front, the back, the top level and the testbench.
`default_nettype none

package rmst_pkg;

	localparam int CNT_W = 11;
	localparam int POS_W = 10;
	localparam int VAL_W = 32;

	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		OP_UPDATE,
		OP_QUERY,
		OP_REPLY_ZERO,
		OP_REPLY_MAX
	} op_t;

	typedef struct packed {
		op_t  op;
		logic status;
	} item_ctl_t;

	localparam int CTL_W = $bits(item_ctl_t);

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_UPD_LEAF,
		B_UPD_UP,
		B_QRY
	} back_state_t;

endpackage

`default_nettype wire

@@ design/rmst_fifo.sv @@
// Short item queue between the front and back parts of the tree.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module rmst_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	logic [W-1:0]  entries_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/rmst_front.sv @@
// Front part: element count register, leaf span search, item accept and
// classification into queue entries. Depends on rmst_pkg.
`default_nettype none

module rmst_front import rmst_pkg::*; #(
	parameter int LEAVES = 1024,
	localparam int LW = $clog2(LEAVES) + 1,
	localparam int UW = (LW > CNT_W) ? LW : CNT_W,
	localparam int QW = $clog2(LEAVES) + 2,
	localparam int ENTRY_W = CTL_W + 2 * QW + VAL_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    kind,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] new_value,
	input  wire logic [CNT_W-1:0]        range_begin,
	input  wire logic [CNT_W-1:0]        range_end,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CNT_W-1:0]        cfg_data,
	input  wire logic                    clearing,
	input  wire logic                    q_full,
	output logic                         q_push,
	output logic [ENTRY_W-1:0]           q_data,
	output logic                         clr_req
);

	logic [CNT_W-1:0] count_q;
	logic [UW-1:0]    span_q;
	logic             span_run_q;
	logic [UW-1:0]    used;
	logic             pos_bad;
	logic             bound_bad;
	logic             empty_rng;
	item_ctl_t        ctl;
	logic [QW-1:0]    idx_a;
	logic [QW-1:0]    idx_b;

	assign cfg_ready = 1'b1;
	assign clr_req   = cfg_valid && cfg_ready;
	assign busy      = span_run_q || clearing || q_full;
	assign q_push    = start && !busy;

	assign used = (UW'(count_q) > UW'(LEAVES)) ? UW'(LEAVES) : UW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_RESET;
			span_q     <= UW'(1);
			span_run_q <= 1'b1;
		end else if (clr_req) begin
			count_q    <= cfg_data;
			span_q     <= UW'(1);
			span_run_q <= 1'b1;
		end else if (span_run_q) begin
			if (span_q < used) begin
				span_q <= span_q << 1;
			end else begin
				span_run_q <= 1'b0;
			end
		end
	end

	assign pos_bad   = (UW'(position) >= used);
	assign bound_bad = (UW'(range_begin) > used) || (UW'(range_end) > used);
	assign empty_rng = (range_begin >= range_end);

	always_comb begin
		if (kind == KIND_QUERY) begin
			ctl.status = bound_bad;
			if (bound_bad || empty_rng) begin
				ctl.op = OP_REPLY_MAX;
			end else begin
				ctl.op = OP_QUERY;
			end
			idx_a = QW'(range_begin) + QW'(span_q);
			idx_b = QW'(range_end) + QW'(span_q);
		end else begin
			ctl.status = pos_bad;
			ctl.op     = pos_bad ? OP_REPLY_ZERO : OP_UPDATE;
			idx_a      = QW'(position) + QW'(span_q);
			idx_b      = '0;
		end
	end

	assign q_data = {ctl, idx_a, idx_b, new_value};

endmodule

`default_nettype wire

@@ design/rmst_back.sv @@
// Back part: node memory with its clearing pass, update and query tree walks,
// result register. Depends on rmst_pkg and the assertion header.
`default_nettype none

`include "range_minimum_segment_tree_top_assert.svh"

module rmst_back import rmst_pkg::*; #(
	parameter int LEAVES = 1024,
	localparam int NW = $clog2(LEAVES) + 1,
	localparam int QW = $clog2(LEAVES) + 2,
	localparam int MEM_D = 2 * LEAVES,
	localparam int ENTRY_W = CTL_W + 2 * QW + VAL_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clr_req,
	output logic                    clearing,
	input  wire logic               q_empty,
	input  wire logic [ENTRY_W-1:0] q_data,
	output logic                    q_pop,
	output logic                    done,
	output logic signed [VAL_W-1:0] minimum,
	output logic                    status
);

	logic signed [VAL_W-1:0] mem [MEM_D];
	logic signed [VAL_W-1:0] rd0_q;
	logic signed [VAL_W-1:0] rd1_q;

	back_state_t             state_q;
	back_state_t             state_d;
	logic [NW-1:0]           clr_q;
	logic [NW-1:0]           i_q;
	logic signed [VAL_W-1:0] cur_q;
	logic [QW-1:0]           l_q;
	logic [QW-1:0]           r_q;
	logic signed [VAL_W-1:0] acc_q;
	logic                    v0_q;
	logic                    v1_q;
	logic                    done_q;
	logic signed [VAL_W-1:0] minimum_q;
	logic                    status_q;

	item_ctl_t               e_ctl;
	logic [QW-1:0]           e_a;
	logic [QW-1:0]           e_b;
	logic signed [VAL_W-1:0] e_val;

	logic                    we;
	logic [NW-1:0]           wa;
	logic signed [VAL_W-1:0] wd;
	logic [NW-1:0]           ra0;
	logic [NW-1:0]           ra1;
	logic [QW-1:0]           r_dec;
	logic signed [VAL_W-1:0] m0;
	logic signed [VAL_W-1:0] m1;
	logic signed [VAL_W-1:0] m01;
	logic signed [VAL_W-1:0] fold;
	logic signed [VAL_W-1:0] up_min;
	logic                    walk_more;

	assign {e_ctl, e_a, e_b, e_val} = q_data;

	assign clearing = (state_q == B_CLEAR);
	assign done     = done_q;
	assign minimum  = minimum_q;
	assign status   = status_q;

	assign r_dec     = r_q - QW'(1);
	assign ra1       = r_dec[NW-1:0];
	assign walk_more = (l_q < r_q);

	assign m0     = v0_q ? rd0_q : VAL_MAX;
	assign m1     = v1_q ? rd1_q : VAL_MAX;
	assign m01    = (m0 < m1) ? m0 : m1;
	assign fold   = (acc_q < m01) ? acc_q : m01;
	assign up_min = (cur_q < rd0_q) ? cur_q : rd0_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == {NW{1'b1}}) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					case (e_ctl.op)
						OP_UPDATE: state_d = B_UPD_LEAF;
						OP_QUERY:  state_d = B_QRY;
						default:   state_d = B_IDLE;
					endcase
				end
			end
			B_UPD_LEAF: begin
				state_d = (i_q == NW'(1)) ? B_IDLE : B_UPD_UP;
			end
			B_UPD_UP: begin
				if (i_q == NW'(1)) begin
					state_d = B_IDLE;
				end
			end
			B_QRY: begin
				if (!walk_more) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
		if (clr_req) begin
			state_d = B_CLEAR;
		end
	end

	always_comb begin
		we    = 1'b0;
		wa    = clr_q;
		wd    = VAL_MAX;
		ra0   = i_q ^ NW'(1);
		q_pop = 1'b0;
		case (state_q)
			B_CLEAR: begin
				we = 1'b1;
			end
			B_IDLE: begin
				q_pop = !q_empty && !clr_req;
			end
			B_UPD_LEAF: begin
				we = 1'b1;
				wa = i_q;
				wd = cur_q;
			end
			B_UPD_UP: begin
				we = 1'b1;
				wa = i_q;
				wd = up_min;
			end
			B_QRY: begin
				ra0 = l_q[NW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			i_q       <= '0;
			cur_q     <= '0;
			l_q       <= '0;
			r_q       <= '0;
			acc_q     <= VAL_MAX;
			v0_q      <= 1'b0;
			v1_q      <= 1'b0;
			done_q    <= 1'b0;
			minimum_q <= '0;
			status_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + NW'(1);
				end
				B_IDLE: begin
					if (q_pop) begin
						case (e_ctl.op)
							OP_UPDATE: begin
								i_q   <= e_a[NW-1:0];
								cur_q <= e_val;
							end
							OP_QUERY: begin
								l_q   <= e_a;
								r_q   <= e_b;
								acc_q <= VAL_MAX;
								v0_q  <= 1'b0;
								v1_q  <= 1'b0;
							end
							default: begin
								done_q    <= 1'b1;
								minimum_q <= (e_ctl.op == OP_REPLY_MAX) ? VAL_MAX : '0;
								status_q  <= e_ctl.status;
							end
						endcase
					end
				end
				B_UPD_LEAF, B_UPD_UP: begin
					if (state_q == B_UPD_UP) begin
						cur_q <= up_min;
					end
					i_q <= i_q >> 1;
					if (i_q == NW'(1)) begin
						done_q    <= 1'b1;
						minimum_q <= '0;
						status_q  <= 1'b0;
					end
				end
				B_QRY: begin
					acc_q <= fold;
					if (walk_more) begin
						v0_q <= l_q[0];
						v1_q <= r_q[0];
						l_q  <= (l_q + QW'(l_q[0])) >> 1;
						r_q  <= (r_q - QW'(r_q[0])) >> 1;
					end else begin
						v0_q      <= 1'b0;
						v1_q      <= 1'b0;
						done_q    <= 1'b1;
						minimum_q <= fold;
						status_q  <= 1'b0;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
			if (clr_req) begin
				clr_q  <= '0;
				done_q <= 1'b0;
			end
		end
	end

	`RMST_ASSERT_NEXT(a_clear_ends, clk, arst_n, (state_q == B_CLEAR && clr_q == {NW{1'b1}} && !clr_req), (state_q == B_IDLE), "clearing pass overran")
	`RMST_ASSERT_IMPL(a_walk_node, clk, arst_n, (state_q == B_UPD_UP), (i_q != '0), "update walk reached node zero")
	`RMST_ASSERT_IMPL(a_no_result_in_clear, clk, arst_n, done_q, ($past(state_q) != B_CLEAR), "result raised from clearing pass")

endmodule

`default_nettype wire

@@ design/range_minimum_segment_tree_top.sv @@
// Top level of the range minimum segment tree: front, item queue and back.
// Depends on rmst_pkg, rmst_front, rmst_fifo and rmst_back.
//
//   channel   ports                                              handshake
//   input     kind position new_value range_begin range_end      start & !busy
//   result    minimum status                                     done, one cycle
//   config    cfg_data (element_count)                           cfg_valid & cfg_ready
//
// An update rewrites its leaf and each node on the way up to the root, a query
// folds node minima from both range ends upward; both walk a tree whose leaf
// count, span, is the power of two in use. Flagged and empty items get no walk.
// After reset and after each element_count write a clearing pass over all 2*LEAVES
// nodes runs, with busy high; up to QUEUE_DEPTH items are taken ahead of the back.
// done cannot be held off by the receiver.
`default_nettype none

module range_minimum_segment_tree_top import rmst_pkg::*; #(
	parameter int LEAVES = 1024,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    kind,
	input  wire logic [POS_W-1:0]        position,
	input  wire logic signed [VAL_W-1:0] new_value,
	input  wire logic [CNT_W-1:0]        range_begin,
	input  wire logic [CNT_W-1:0]        range_end,
	output logic                         done,
	output logic signed [VAL_W-1:0]      minimum,
	output logic                         status,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CNT_W-1:0]        cfg_data
);

	localparam int QW = $clog2(LEAVES) + 2;
	localparam int ENTRY_W = CTL_W + 2 * QW + VAL_W;

	logic               clearing;
	logic               clr_req;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_wdata;
	logic [ENTRY_W-1:0] q_rdata;

	rmst_front #(
		.LEAVES(LEAVES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.position   (position),
		.new_value  (new_value),
		.range_begin(range_begin),
		.range_end  (range_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.clearing   (clearing),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.clr_req    (clr_req)
	);

	rmst_fifo #(
		.W    (ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	rmst_back #(
		.LEAVES(LEAVES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr_req (clr_req),
		.clearing(clearing),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.done    (done),
		.minimum (minimum),
		.status  (status)
	);

endmodule

`default_nettype wire

@@ tb/tb_range_minimum_segment_tree_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of range_minimum_segment_tree_top: a directed table, then
// random update and query items under several element_count settings, scored
// against a testbench tree model or typed table rows. Depends on rmst_pkg and the RTL.
`default_nettype none

module tb_range_minimum_segment_tree_top;
	import rmst_pkg::*;

	localparam int LEAVES = 1024;
	localparam int NODES = 2 * LEAVES;
	localparam logic KIND_UPDATE = ~KIND_QUERY;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FLAG = 1'b1;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 12000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 66;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		logic signed [VAL_W-1:0] minimum;
		logic                    status;
	} rmq_result_t;

	typedef struct {
		row_kind_t               rk;
		logic                    kind;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]        lo;
		logic [CNT_W-1:0]        hi;
		bit                      typed;
		rmq_result_t             res;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    kind = 1'b0;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] new_value = '0;
	logic [CNT_W-1:0]        range_begin = '0;
	logic [CNT_W-1:0]        range_end = '0;
	logic                    cfg_valid = 1'b0;
	logic [CNT_W-1:0]        cfg_data = '0;
	logic                    busy;
	logic                    done;
	logic signed [VAL_W-1:0] minimum;
	logic                    status;
	logic                    cfg_ready;

	logic signed [VAL_W-1:0] seg_nodes [0:NODES-1];
	int unsigned             seg_count;
	int unsigned             seg_span;

	rmq_result_t expected_q [$];
	dir_row_t    dir_rows [$];

	int errors = 0;
	int stall_cycles = 0;
	int n_items = 0;
	int n_updates = 0;
	int n_flagged = 0;
	int n_results = 0;
	int n_cfg = 0;

	range_minimum_segment_tree_top #(.LEAVES(LEAVES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.new_value(new_value),
		.range_begin(range_begin),
		.range_end(range_end),
		.done(done),
		.minimum(minimum),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void clear_tree(input logic [CNT_W-1:0] cnt);
		seg_count = (cnt > LEAVES) ? LEAVES : cnt;
		seg_span = 1;
		while (seg_span < seg_count)
			seg_span = seg_span << 1;
		for (int i = 0; i < NODES; i++)
			seg_nodes[i] = VAL_MAX;
	endfunction

	function automatic logic signed [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic rmq_result_t tree_step(input logic k, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hi);
		rmq_result_t r;
		int unsigned i;
		int unsigned l;
		int unsigned rr;
		r.minimum = VAL_MAX;
		r.status = STATUS_OK;
		if (k == KIND_UPDATE) begin
			r.minimum = '0;
			if (pos >= seg_count) begin
				r.status = STATUS_FLAG;
				return r;
			end
			i = pos + seg_span;
			seg_nodes[i] = val;
			while (i > 1) begin
				i = i >> 1;
				seg_nodes[i] = smin(seg_nodes[2 * i], seg_nodes[2 * i + 1]);
			end
			return r;
		end
		if (lo > seg_count || hi > seg_count) begin
			r.status = STATUS_FLAG;
			return r;
		end
		if (lo < hi) begin
			l = lo + seg_span;
			rr = hi + seg_span;
			while (l < rr) begin
				if (l[0]) begin
					r.minimum = smin(r.minimum, seg_nodes[l]);
					l++;
				end
				if (rr[0]) begin
					rr--;
					r.minimum = smin(r.minimum, seg_nodes[rr]);
				end
				l = l >> 1;
				rr = rr >> 1;
			end
		end
		return r;
	endfunction

	task automatic send_item(input logic k, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hi, input int gap, input bit typed,
			input rmq_result_t typed_res);
		rmq_result_t r;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		position <= pos;
		new_value <= val;
		range_begin <= lo;
		range_end <= hi;
		do @(posedge clk); while (busy);
		r = tree_step(k, pos, val, lo, hi);
		if (typed)
			r = typed_res;
		expected_q.push_back(r);
		n_items++;
		if (k == KIND_UPDATE)
			n_updates++;
		if (r.status == STATUS_FLAG)
			n_flagged++;
	endtask

	task automatic write_count(input logic [CNT_W-1:0] cnt);
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cnt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= CNT_W'($urandom_range(0, 2047));
		clear_tree(cnt);
		n_cfg++;
	endtask

	task automatic add_row(input row_kind_t rk, input logic k, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, input logic [CNT_W-1:0] lo,
			input logic [CNT_W-1:0] hi, input bit typed,
			input logic signed [VAL_W-1:0] emin, input logic estat);
		dir_row_t row;
		row.rk = rk;
		row.kind = k;
		row.position = pos;
		row.value = val;
		row.lo = lo;
		row.hi = hi;
		row.typed = typed;
		row.res.minimum = emin;
		row.res.status = estat;
		dir_rows.push_back(row);
	endtask

	always @(posedge clk) begin
		rmq_result_t e;
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					expected_q.size());
				$display("FAILURE");
				$finish;
			end
			if (done) begin
				n_results++;
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: minimum %0d status %0b",
						$time, minimum, status);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (minimum !== e.minimum) begin
						$display("%0t: minimum mismatch: expected %0d actual %0d", $time,
							e.minimum, minimum);
						errors++;
					end
					if (status !== e.status) begin
						$display("%0t: status mismatch: expected %0b actual %0b", $time,
							e.status, status);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int unsigned phase_cnt [PHASES];
		int unsigned used;
		int unsigned pick;
		int gap;
		logic k;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		rmq_result_t none;

		phase_cnt = '{1, 2, 3, 8, 37, 512, 513, 1023, 1024, 0, 1500, 700};
		none.minimum = '0;
		none.status = STATUS_OK;
		clear_tree(CNT_RESET);

		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 1024, 1, VAL_MAX, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 1023, VAL_MIN, 0, 0, 1, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 1023, 1024, 1, VAL_MIN, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 0, VAL_MAX, 0, 0, 1, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 511, -5, 2047, 2047, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 1024, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 1023, -1, 0, 1023, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 512, 1024, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 1025, 1024, 1, VAL_MAX, STATUS_FLAG);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 2047, 1, VAL_MAX, STATUS_FLAG);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 7, 7, 1, VAL_MAX, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 10, 3, 1, VAL_MAX, STATUS_OK);
		add_row(ROW_CFG, KIND_UPDATE, 0, 0, 0, 5, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 5, 1, 0, 0, 1, 0, STATUS_FLAG);
		add_row(ROW_ITEM, KIND_UPDATE, 4, 100, 0, 0, 1, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 6, 1, VAL_MAX, STATUS_FLAG);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 5, 1, 100, STATUS_OK);
		add_row(ROW_CFG, KIND_UPDATE, 0, 0, 0, 0, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 0, 3, 0, 0, 1, 0, STATUS_FLAG);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 0, 1, VAL_MAX, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 0, 1, 1, VAL_MAX, STATUS_FLAG);
		add_row(ROW_CFG, KIND_UPDATE, 0, 0, 0, 2047, 0, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_UPDATE, 1023, -1, 0, 0, 1, 0, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 1023, 1024, 1, -1, STATUS_OK);
		add_row(ROW_ITEM, KIND_QUERY, 0, 0, 1024, 1024, 1, VAL_MAX, STATUS_OK);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].rk == ROW_CFG)
				write_count(dir_rows[i].hi);
			else
				send_item(dir_rows[i].kind, dir_rows[i].position, dir_rows[i].value,
					dir_rows[i].lo, dir_rows[i].hi, $urandom_range(0, 6),
					dir_rows[i].typed, dir_rows[i].res);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_count(CNT_W'(phase_cnt[p]));
			used = seg_count;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				gap = ((n % 32) < 8) ? 0 : $urandom_range(0, 6);
				pick = $urandom_range(0, 99);
				pos = POS_W'($urandom_range(0, 1023));
				lo = CNT_W'($urandom_range(0, 2047));
				hi = CNT_W'($urandom_range(0, 2047));
				case ($urandom_range(0, 7))
					0: val = VAL_MAX;
					1: val = VAL_MIN;
					2, 3: val = $signed($urandom_range(0, 40)) - 20;
					default: val = $urandom;
				endcase
				if (pick < 50) begin
					k = KIND_UPDATE;
					if (used > 0 && pick < 44)
						pos = POS_W'($urandom_range(0, used - 1));
				end else begin
					k = KIND_QUERY;
					if (pick < 80) begin
						lo = CNT_W'($urandom_range(0, used));
						hi = CNT_W'($urandom_range(lo, used));
					end else if (pick < 92) begin
						lo = CNT_W'($urandom_range(0, used));
						hi = CNT_W'($urandom_range(0, used));
					end
				end
				send_item(k, pos, val, lo, hi, gap, 0, none);
			end
		end

		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d updates, %0d flagged), %0d results, %0d count writes",
			n_items, n_updates, n_flagged, n_results, n_cfg);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/rmst_pkg.sv
design/rmst_fifo.sv
design/rmst_front.sv
design/rmst_back.sv
design/range_minimum_segment_tree_top.sv
tb/tb_range_minimum_segment_tree_top.sv
